### hw/rtl/msp_pkg.sv
`timescale 1ns / 1ps

package msp_pkg;

  // default sizes
  localparam int unsigned NumCells  = 1024;
  localparam int unsigned NumStacks = 4;
  localparam int unsigned DataW     = 32;

  // command codes, the unused code decodes as peek
  typedef enum logic [1:0] {
    CMD_PUSH = 2'd0,
    CMD_POP  = 2'd1,
    CMD_PEEK = 2'd2
  } cmd_e;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  // engine sequencer states
  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_e;

  // input item
  typedef struct packed {
    logic        [1:0]       command;
    logic        [1:0]       stack_id;
    logic signed [DataW-1:0] data_in;
  } cmd_t;

  // result item
  typedef struct packed {
    logic signed [DataW-1:0] value_out;
    logic                    now_empty;
    logic        [1:0]       status;
  } res_t;

  // cell memory strobes
  typedef struct packed {
    logic rd_en;
    logic val_we;
    logic link_we;
  } mem_ctrl_t;

endpackage

### hw/rtl/multi_stack_shared_pool_unit.sv
`timescale 1ns / 1ps

// Several LIFO stacks sharing one pool of cells through a free list.
// Input channel (in_valid_i/in_ready_o/in_item_i) takes one command item:
// push data_in onto stack_id, pop it, or peek at its top (code three acts
// as peek; a stack id beyond the stack count wraps round).
// Output channel (out_valid_o/out_ready_i/out_item_o) gives one result item
// per command: the value, whether the stack is empty afterwards, and a
// status of ok, pool full (push refused) or stack empty (pop/peek refused).
// Each item takes two steps: one reads the cell value and link memories,
// one writes back and loads the output register. The result is offered
// from the output register; no new item is accepted until the current one
// has been written back.
// The output register lets the next item be taken while a result waits;
// if it is still held when the following result is ready, the engine
// stalls in its write-back cycle until the receiver takes it.
// After reset all stacks are empty and every cell is free, in order from
// cell 0; no clearing sweep is needed, items are accepted at once.
module multi_stack_shared_pool_unit #(
  parameter int unsigned CELLS  = msp_pkg::NumCells,
  parameter int unsigned STACKS = msp_pkg::NumStacks
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  msp_pkg::cmd_t in_item_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output msp_pkg::res_t out_item_o
);

  import msp_pkg::*;

  localparam int unsigned PtrW = $clog2(CELLS + 1);
  localparam int unsigned IdxW = $clog2(CELLS);

  mem_ctrl_t        mem;
  logic [IdxW-1:0]  rd_addr, wr_addr;
  logic [DataW-1:0] wr_value, val_rd;
  logic [PtrW-1:0]  wr_link, link_rd;
  logic             res_valid, res_stall;
  res_t             res;
  logic             out_valid_q;
  res_t             out_item_q;

  // sequencer, stack heads and free list
  msp_engine #(
    .CELLS  (CELLS),
    .STACKS (STACKS)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .res_stall_i (res_stall),
    .res_valid_o (res_valid),
    .res_o       (res),
    .mem_o       (mem),
    .rd_addr_o   (rd_addr),
    .wr_addr_o   (wr_addr),
    .wr_value_o  (wr_value),
    .wr_link_o   (wr_link),
    .val_rd_i    (val_rd),
    .link_rd_i   (link_rd)
  );

  // cell values
  msp_ram #(
    .Width (DataW),
    .Depth (CELLS)
  ) u_value_ram (
    .clk_i   (clk_i),
    .we_i    (mem.val_we),
    .waddr_i (wr_addr),
    .wdata_i (wr_value),
    .re_i    (mem.rd_en),
    .raddr_i (rd_addr),
    .rdata_o (val_rd)
  );

  // cell links
  msp_ram #(
    .Width (PtrW),
    .Depth (CELLS)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (mem.link_we),
    .waddr_i (wr_addr),
    .wdata_i (wr_link),
    .re_i    (mem.rd_en),
    .raddr_i (rd_addr),
    .rdata_o (link_rd)
  );

  // output register
  assign res_stall = out_valid_q && !out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      out_item_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // engine is busy for the cycle after an accept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("item accepted on consecutive cycles");

  // a new result never overwrites one still held
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(res_valid && out_valid_q && !out_ready_i))
    else $error("result overwrote a held item");

  // refused commands carry a zero value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_item_o.status != ST_OK) |-> (out_item_o.value_out == '0))
    else $error("refused item with non-zero value");

  // an empty refusal always reports the stack empty
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_item_o.status == ST_EMPTY) |-> out_item_o.now_empty)
    else $error("empty status without empty flag");

endmodule

### hw/rtl/msp_ram.sv
`timescale 1ns / 1ps

module msp_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // one write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read, data held while no read is issued
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/msp_engine.sv
`timescale 1ns / 1ps

module msp_engine #(
  parameter int unsigned CELLS  = msp_pkg::NumCells,
  parameter int unsigned STACKS = msp_pkg::NumStacks
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  msp_pkg::cmd_t                     in_item_i,
  input  logic                              res_stall_i,
  output logic                              res_valid_o,
  output msp_pkg::res_t                     res_o,
  output msp_pkg::mem_ctrl_t                mem_o,
  output logic [$clog2(CELLS)-1:0]          rd_addr_o,
  output logic [$clog2(CELLS)-1:0]          wr_addr_o,
  output logic [msp_pkg::DataW-1:0]         wr_value_o,
  output logic [$clog2(CELLS+1)-1:0]        wr_link_o,
  input  logic [msp_pkg::DataW-1:0]         val_rd_i,
  input  logic [$clog2(CELLS+1)-1:0]        link_rd_i
);

  import msp_pkg::*;

  localparam int unsigned PtrW     = $clog2(CELLS + 1);
  localparam int unsigned IdxW     = $clog2(CELLS);
  localparam int unsigned SidW     = (STACKS > 1) ? $clog2(STACKS) : 1;
  localparam int unsigned SidFullW = 9;
  localparam logic [PtrW-1:0] NullPtr = PtrW'(CELLS);

  state_e            state_q, state_d;
  logic [PtrW-1:0]   free_q, free_d;
  logic [PtrW-1:0]   mark_q, mark_d;
  logic [PtrW-1:0]   head_q [STACKS];
  logic              head_we;
  logic [PtrW-1:0]   head_wdata;
  logic              push_q, pop_q;
  logic [SidW-1:0]   sid_q;
  logic [DataW-1:0]  data_q;
  logic [PtrW-1:0]   top_q;
  logic [PtrW-1:0]   cell_q;

  logic [SidFullW-1:0] sid_full;
  logic [SidW-1:0]     sid;
  logic [PtrW-1:0]     top;
  logic [PtrW-1:0]     target;
  logic                accept;
  logic [PtrW-1:0]     link_eff;

  assign accept = in_valid_i && (state_q == S_IDLE);

  // stack id folded into range by repeated subtraction, at most three steps
  always_comb begin
    sid_full = SidFullW'(in_item_i.stack_id);
    for (int k = 0; k < 3; k++) begin
      if (sid_full >= SidFullW'(STACKS)) begin
        sid_full = sid_full - SidFullW'(STACKS);
      end
    end
  end

  assign sid    = sid_full[SidW-1:0];
  assign top    = head_q[sid];
  assign target = (in_item_i.command == CMD_PUSH) ? free_q : top;

  // cells at or above the fill mark were never written: link is the next cell
  assign link_eff = (cell_q >= mark_q) ? PtrW'(cell_q + PtrW'(1)) : link_rd_i;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (!res_stall_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // read issue, write-back and result
  always_comb begin
    in_ready_o    = 1'b0;
    mem_o         = '0;
    rd_addr_o     = target[IdxW-1:0];
    wr_addr_o     = cell_q[IdxW-1:0];
    wr_value_o    = data_q;
    wr_link_o     = push_q ? top_q : free_q;
    res_valid_o   = 1'b0;
    res_o         = '0;
    head_we       = 1'b0;
    head_wdata    = cell_q;
    free_d        = free_q;
    mark_d        = mark_q;
    case (state_q)
      S_IDLE: begin
        in_ready_o  = 1'b1;
        mem_o.rd_en = in_valid_i && (target != NullPtr);
      end
      S_EXEC: begin
        res_valid_o = !res_stall_i;
        if (push_q) begin
          if (cell_q == NullPtr) begin
            res_o.status    = ST_FULL;
            res_o.now_empty = (top_q == NullPtr);
          end else begin
            res_o.value_out = data_q;
            res_o.status    = ST_OK;
            if (!res_stall_i) begin
              mem_o.val_we  = 1'b1;
              mem_o.link_we = 1'b1;
              head_we       = 1'b1;
              head_wdata    = cell_q;
              free_d        = link_eff;
              if (cell_q == mark_q) begin
                mark_d = PtrW'(mark_q + PtrW'(1));
              end
            end
          end
        end else if (cell_q == NullPtr) begin
          res_o.status    = ST_EMPTY;
          res_o.now_empty = 1'b1;
        end else begin
          res_o.value_out = val_rd_i;
          res_o.status    = ST_OK;
          if (pop_q) begin
            res_o.now_empty = (link_eff == NullPtr);
            if (!res_stall_i) begin
              mem_o.link_we = 1'b1;
              head_we       = 1'b1;
              head_wdata    = link_eff;
              free_d        = cell_q;
            end
          end
        end
      end
      default: ;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      free_q  <= '0;
      mark_q  <= '0;
      for (int i = 0; i < STACKS; i++) begin
        head_q[i] <= NullPtr;
      end
    end else begin
      state_q <= state_d;
      free_q  <= free_d;
      mark_q  <= mark_d;
      if (head_we) begin
        head_q[sid_q] <= head_wdata;
      end
    end
  end

  // item captured at accept
  always_ff @(posedge clk_i) begin
    if (accept) begin
      push_q <= (in_item_i.command == CMD_PUSH);
      pop_q  <= (in_item_i.command == CMD_POP);
      sid_q  <= sid;
      data_q <= in_item_i.data_in;
      top_q  <= top;
      cell_q <= target;
    end
  end

endmodule
